### rtl/assert_macros.svh
// Assertion macros for the RTL of the slot allocator.
// No dependencies; included by page_slab_slot_allocator, which carries the concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define PSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define PSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/psa_pkg.sv
// Types and constants for the page slot allocator.
// No dependencies; used by page_slab_slot_allocator.
package psa_pkg;

    localparam int OFFSET_W    = 13;
    localparam int COUNT_W     = 11;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 2;

    // count ceiling, also guards against a zero slot size
    localparam logic [COUNT_W-1:0] USED_MAX = 11'd2047;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_SLOT_BYTES = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_SLOT = 2'd1;

    localparam logic [CFG_DATA_W-1:0] SLOT_BYTES_RST = 13'd64;
    localparam logic [CFG_DATA_W-1:0] FIRST_SLOT_RST = 13'd64;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_RESTART = 2'd2,
        OP_NOP     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        REL_NONE            = 2'd0,
        REL_BACK_FROM_FULL  = 2'd1,
        REL_NO_SLOTS_IN_USE = 2'd2,
        REL_ERROR           = 2'd3
    } t_release;

    typedef struct packed {
        t_op                 op;
        logic [OFFSET_W-1:0] free_offset;
    } t_req;

    typedef struct packed {
        logic                granted;
        logic [OFFSET_W-1:0] slot_offset;
        t_release            release_status;
        logic                now_full;
        logic [COUNT_W-1:0]  slots_in_use;
    } t_rsp;

endpackage

### rtl/page_slab_slot_allocator.sv
// Top level of the page slot allocator: free list head, use count, link table.
// Depends on psa_pkg, psa_ram and assert_macros.svh.
//
//  channel   | direction | handshake                      | payload
//  ----------+-----------+--------------------------------+-----------------------
//  request   | in        | i_start, o_busy                | i_req (psa_pkg::t_req)
//  response  | out       | o_rsp_valid (one-cycle strobe) | o_rsp (psa_pkg::t_rsp)
//  config    | in        | i_cfg_valid, o_cfg_ready       | i_cfg_index, i_cfg_data
//
// A request transfers when i_start is high and o_busy is low. Its response strobes
// after the ST_FIN state, and a new request can transfer in that same strobe cycle;
// the block takes no new request while one is in ST_FIN, where the registered read
// of the link memory returns when a recycled slot is popped. After reset release the
// block is busy in ST_INIT while it writes a null link at the initial head. The
// response side never stalls; o_cfg_ready is always high.
`include "assert_macros.svh"

module page_slab_slot_allocator #(
    parameter int PAGE_SHIFT_BITS = 13,
    parameter int GRAIN_BYTES     = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  psa_pkg::t_req                       i_req,
    output logic                                o_rsp_valid,
    output psa_pkg::t_rsp                       o_rsp,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [psa_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [psa_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int PW    = PAGE_SHIFT_BITS;
    localparam int GSH   = $clog2(GRAIN_BYTES);
    localparam int AW    = PW - GSH;
    localparam int DEPTH = 1 << AW;
    localparam int SUM_W = ((PW > psa_pkg::CFG_DATA_W) ? PW : psa_pkg::CFG_DATA_W) + 1;
    localparam logic [SUM_W-1:0] PAGE_LIMIT = SUM_W'(1) << PW;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_FIN
    } t_state;

    // page full: null head, count at ceiling, or frontier cannot bump inside the page
    function automatic logic page_full(
        input logic [PW-1:0]                    head,
        input logic [psa_pkg::COUNT_W-1:0]      used,
        input logic [PW-1:0]                    link,
        input logic [psa_pkg::CFG_DATA_W-1:0]   slot_bytes
    );
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(slot_bytes);
        return (head == '0) || (used == psa_pkg::USED_MAX) ||
               ((link == '0) && (sum >= PAGE_LIMIT));
    endfunction

    t_state                          r_state;
    logic [PW-1:0]                   r_head;
    logic [psa_pkg::COUNT_W-1:0]     r_used;
    logic [PW-1:0]                   r_head_link;  // copy of the link at the head
    logic                            r_pop;
    logic                            r_rsp_valid;
    logic                            r_granted;
    logic [psa_pkg::OFFSET_W-1:0]    r_slot;
    psa_pkg::t_release               r_status;
    psa_pkg::t_rsp                   r_rsp;
    logic [psa_pkg::CFG_DATA_W-1:0]  r_slot_bytes;
    logic [psa_pkg::CFG_DATA_W-1:0]  r_first;

    logic [PW-1:0]                   n_head;
    logic [psa_pkg::COUNT_W-1:0]     n_used;
    logic [PW-1:0]                   n_head_link;
    logic                            n_pop;
    logic                            n_granted;
    logic [psa_pkg::OFFSET_W-1:0]    n_slot;
    psa_pkg::t_release               n_status;

    logic                            accept;
    logic                            full_now;
    logic [SUM_W-1:0]                bump_sum;
    logic [PW-1:0]                   bump_head;
    logic [PW-1:0]                   free_off;
    logic [PW-1:0]                   restart_head;
    logic [psa_pkg::COUNT_W-1:0]     used_dec;
    logic                            mem_we;
    logic [AW-1:0]                   mem_waddr;
    logic [PW-1:0]                   mem_wdata;
    logic                            mem_re;
    logic [AW-1:0]                   mem_raddr;
    logic [PW-1:0]                   mem_rdata;
    logic [PW-1:0]                   fin_link;
    logic                            fin_full;

    // next-link table, indexed by offset / grain
    psa_ram #(
        .WIDTH (PW),
        .DEPTH (DEPTH)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // configuration registers, always ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_bytes <= psa_pkg::SLOT_BYTES_RST;
            r_first      <= psa_pkg::FIRST_SLOT_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == psa_pkg::CFG_SLOT_BYTES) begin
                r_slot_bytes <= i_cfg_data;
            end else if (i_cfg_index == psa_pkg::CFG_FIRST_SLOT) begin
                r_first <= i_cfg_data;
            end
        end
    end

    assign o_cfg_ready = 1'b1;

    // decode the request against the current head and issue the link access
    always_comb begin
        accept       = (r_state == ST_IDLE) && i_start;
        full_now     = page_full(r_head, r_used, r_head_link, r_slot_bytes);
        bump_sum     = SUM_W'(r_head) + SUM_W'(r_slot_bytes);
        bump_head    = PW'(bump_sum);
        free_off     = PW'(i_req.free_offset);
        restart_head = PW'(r_first);
        used_dec     = r_used - 1'b1;

        n_head      = r_head;
        n_used      = r_used;
        n_head_link = r_head_link;
        n_pop       = 1'b0;
        n_granted   = 1'b0;
        n_slot      = '0;
        n_status    = psa_pkg::REL_NONE;
        mem_we      = 1'b0;
        mem_waddr   = r_head[PW-1:GSH];
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = r_head_link[PW-1:GSH];

        if (r_state == ST_INIT) begin
            // null link at the head left by reset
            mem_we = 1'b1;
        end else if (accept) begin
            unique case (i_req.op)
                psa_pkg::OP_ALLOC: begin
                    if (!full_now) begin
                        n_granted = 1'b1;
                        n_slot    = psa_pkg::OFFSET_W'(r_head);
                        n_used    = r_used + 1'b1;
                        if (r_head_link == '0) begin
                            // bump the frontier, new frontier gets a null link
                            n_head      = bump_head;
                            n_head_link = '0;
                            mem_we      = 1'b1;
                            mem_waddr   = bump_head[PW-1:GSH];
                        end else begin
                            // pop a recycled slot, fetch its link
                            n_head = r_head_link;
                            n_pop  = 1'b1;
                            mem_re = 1'b1;
                        end
                    end
                end
                psa_pkg::OP_FREE: begin
                    if ((r_used == '0) || (free_off == '0)) begin
                        n_status = psa_pkg::REL_ERROR;
                    end else begin
                        // push: freed slot links to the old head
                        mem_we      = 1'b1;
                        mem_waddr   = free_off[PW-1:GSH];
                        mem_wdata   = r_head;
                        n_head      = free_off;
                        n_head_link = r_head;
                        n_used      = used_dec;
                        if (used_dec == '0) begin
                            n_status = psa_pkg::REL_NO_SLOTS_IN_USE;
                        end else if (full_now) begin
                            n_status = psa_pkg::REL_BACK_FROM_FULL;
                        end
                    end
                end
                psa_pkg::OP_RESTART: begin
                    n_head      = restart_head;
                    n_used      = '0;
                    n_head_link = '0;
                    mem_we      = 1'b1;
                    mem_waddr   = restart_head[PW-1:GSH];
                end
                psa_pkg::OP_NOP: begin
                end
            endcase
        end

        // in ST_FIN: the popped head's link arrives from memory
        fin_link = r_pop ? mem_rdata : r_head_link;
        fin_full = page_full(r_head, r_used, fin_link, r_slot_bytes);
    end

    // sequencer and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_head      <= PW'(psa_pkg::FIRST_SLOT_RST);
            r_used      <= '0;
            r_head_link <= '0;
            r_pop       <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_rsp_valid <= 1'b0;
            unique case (r_state)
                ST_INIT: begin
                    r_state <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_state     <= ST_FIN;
                        r_head      <= n_head;
                        r_used      <= n_used;
                        r_head_link <= n_head_link;
                        r_pop       <= n_pop;
                    end
                end
                ST_FIN: begin
                    r_state     <= ST_IDLE;
                    r_head_link <= fin_link;
                    r_pop       <= 1'b0;
                    r_rsp_valid <= 1'b1;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // response payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_granted <= n_granted;
            r_slot    <= n_slot;
            r_status  <= n_status;
        end
        if (r_state == ST_FIN) begin
            r_rsp.granted        <= r_granted;
            r_rsp.slot_offset    <= r_slot;
            r_rsp.release_status <= r_status;
            r_rsp.now_full       <= fin_full;
            r_rsp.slots_in_use   <= r_used;
        end
    end

    assign o_busy      = (r_state != ST_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // checks
    `PSA_ASSERT_NEXT(a_accept_then_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy && !o_rsp_valid, "transfer did not start a busy cycle")
    `PSA_ASSERT_NEXT(a_fin_strobes, i_clk, i_rst_n, r_state == ST_FIN, o_rsp_valid && !o_busy, "finishing cycle gave no response")
    `PSA_ASSERT_IMP(a_grant_counts, i_clk, i_rst_n, o_rsp_valid && o_rsp.granted, (o_rsp.release_status == psa_pkg::REL_NONE) && (o_rsp.slots_in_use != '0), "grant with release status or zero count")
    `PSA_ASSERT_IMP(a_pop_is_grant, i_clk, i_rst_n, (r_state == ST_FIN) && r_pop, r_granted, "link fetch without a grant")

endmodule

### rtl/psa_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies; holds the next-link table of the slot allocator.
module psa_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### dv/tb_page_slab_slot_allocator.sv
// Self-checking testbench for page_slab_slot_allocator: directed and random
// allocate/free/restart traffic, checked against an in-bench free list predictor.
// Depends on psa_pkg and the allocator RTL.
module tb_page_slab_slot_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAGE_BYTES    = 8192;
    localparam int LINK_DEPTH    = 1024;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_ITEMS   = 140;
    localparam int ZERO_ALLOCS   = 24;
    // indexes with no register behind them
    localparam logic [psa_pkg::CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [psa_pkg::CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_start;
    logic                            o_busy;
    psa_pkg::t_req                   i_req;
    logic                            o_rsp_valid;
    psa_pkg::t_rsp                   o_rsp;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [psa_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [psa_pkg::CFG_DATA_W-1:0]  i_cfg_data;

    // predictor state
    logic [psa_pkg::OFFSET_W-1:0]   cfg_slot_bytes;
    logic [psa_pkg::OFFSET_W-1:0]   cfg_first_slot;
    logic [psa_pkg::OFFSET_W-1:0]   pg_head;
    logic [psa_pkg::COUNT_W-1:0]    pg_used;
    logic [psa_pkg::OFFSET_W-1:0]   pg_link [LINK_DEPTH];

    psa_pkg::t_rsp                  expected_rsps [$];
    logic [psa_pkg::OFFSET_W-1:0]   held_slots [$];
    int                             mismatches;
    int                             stall_cycles;

    page_slab_slot_allocator DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Free list predictor
    // ---------------------------------------------------------------

    // link entry for an offset: one per 8 byte grain
    function automatic logic [9:0] link_slot(logic [psa_pkg::OFFSET_W-1:0] off);
        return off[psa_pkg::OFFSET_W-1:3];
    endfunction

    function automatic bit page_is_full();
        if (pg_head == '0 || pg_used >= psa_pkg::USED_MAX)
            return 1'b1;
        return (pg_link[link_slot(pg_head)] == '0) &&
               (int'(pg_head) + int'(cfg_slot_bytes) >= PAGE_BYTES);
    endfunction

    task automatic restart_page();
        pg_head = cfg_first_slot;
        pg_used = '0;
        pg_link[link_slot(pg_head)] = '0;
    endtask

    task automatic slab_step(input psa_pkg::t_req req, output psa_pkg::t_rsp rsp);
        logic [psa_pkg::OFFSET_W-1:0] nxt;
        bit                           was_full;
        rsp = '0;
        case (req.op)
            psa_pkg::OP_ALLOC: begin
                if (!page_is_full()) begin
                    nxt = pg_link[link_slot(pg_head)];
                    rsp.slot_offset = pg_head;
                    if (nxt == '0) begin
                        // bump the frontier
                        pg_head = pg_head + cfg_slot_bytes;
                        pg_link[link_slot(pg_head)] = '0;
                    end else begin
                        pg_head = nxt;
                    end
                    pg_used++;
                    rsp.granted = 1'b1;
                end
            end
            psa_pkg::OP_FREE: begin
                if (pg_used == '0 || req.free_offset == '0) begin
                    rsp.release_status = psa_pkg::REL_ERROR;
                end else begin
                    was_full = page_is_full();
                    pg_link[link_slot(req.free_offset)] = pg_head;
                    pg_head = req.free_offset;
                    pg_used--;
                    if (pg_used == '0)
                        rsp.release_status = psa_pkg::REL_NO_SLOTS_IN_USE;
                    else if (was_full)
                        rsp.release_status = psa_pkg::REL_BACK_FROM_FULL;
                end
            end
            psa_pkg::OP_RESTART: restart_page();
            default: ;
        endcase
        rsp.now_full     = page_is_full();
        rsp.slots_in_use = pg_used;
    endtask

    // ---------------------------------------------------------------
    // Driving
    // ---------------------------------------------------------------

    // mostly back to back, some short gaps, a few long ones
    function automatic int gap_cycles(bit calm);
        int pick;
        if (calm)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // one request transfer, predicted on acceptance, then an optional gap
    task automatic send_req(input psa_pkg::t_op op,
                            input logic [psa_pkg::OFFSET_W-1:0] off,
                            input bit calm, output psa_pkg::t_rsp want);
        psa_pkg::t_req req;
        int            gap;
        req.op          = op;
        req.free_offset = off;
        @(negedge i_clk);
        i_start <= 1'b1;
        i_req   <= req;
        do @(posedge i_clk); while (o_busy);
        slab_step(req, want);
        expected_rsps.push_back(want);
        gap = gap_cycles(calm);
        if (gap > 0) begin
            @(negedge i_clk);
            i_start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic cfg_write(input logic [psa_pkg::CFG_INDEX_W-1:0] index,
                             input logic [psa_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            psa_pkg::CFG_SLOT_BYTES: cfg_slot_bytes = data;
            psa_pkg::CFG_FIRST_SLOT: cfg_first_slot = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // stop issuing and let every outstanding response come back
    task automatic drain();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (expected_rsps.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned want);
        $display("tb: mismatch on %s at %0t: got %0d, expected %0d",
                 field, $realtime, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : rsp_check
        psa_pkg::t_rsp want;
        if (i_rst_n === 1'b1 && o_rsp_valid === 1'b1) begin
            if (expected_rsps.size() == 0) begin
                report_mismatch("unexpected response", 1, 0);
            end else begin
                want = expected_rsps.pop_front();
                if (o_rsp.granted !== want.granted)
                    report_mismatch("granted", o_rsp.granted, want.granted);
                if (o_rsp.slot_offset !== want.slot_offset)
                    report_mismatch("slot_offset", o_rsp.slot_offset, want.slot_offset);
                if (o_rsp.release_status !== want.release_status)
                    report_mismatch("release_status", o_rsp.release_status,
                                    want.release_status);
                if (o_rsp.now_full !== want.now_full)
                    report_mismatch("now_full", o_rsp.now_full, want.now_full);
                if (o_rsp.slots_in_use !== want.slots_in_use)
                    report_mismatch("slots_in_use", o_rsp.slots_in_use,
                                    want.slots_in_use);
            end
        end
    end

    // watchdog: too long without any transfer ends the run
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_rsp_valid || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // every op at reset settings: bump, recycle, null and empty frees,
    // misaligned free, double free cycle, no-op, restart
    task automatic test_basic_ops();
        psa_pkg::t_rsp want;
        send_req(psa_pkg::OP_FREE,    13'd64,   1'b0, want);
        send_req(psa_pkg::OP_ALLOC,   13'd0,    1'b0, want);
        send_req(psa_pkg::OP_ALLOC,   13'd0,    1'b0, want);
        send_req(psa_pkg::OP_ALLOC,   13'd0,    1'b0, want);
        send_req(psa_pkg::OP_FREE,    13'd0,    1'b0, want);
        send_req(psa_pkg::OP_FREE,    13'd128,  1'b0, want);
        send_req(psa_pkg::OP_ALLOC,   13'd0,    1'b0, want);
        send_req(psa_pkg::OP_FREE,    13'd67,   1'b0, want);
        send_req(psa_pkg::OP_ALLOC,   13'd0,    1'b0, want);
        send_req(psa_pkg::OP_FREE,    13'd8191, 1'b0, want);
        send_req(psa_pkg::OP_FREE,    13'd8191, 1'b0, want);
        send_req(psa_pkg::OP_ALLOC,   13'd0,    1'b0, want);
        send_req(psa_pkg::OP_ALLOC,   13'd0,    1'b0, want);
        send_req(psa_pkg::OP_NOP,     13'h1555, 1'b0, want);
        send_req(psa_pkg::OP_RESTART, 13'h0AAA, 1'b0, want);
        send_req(psa_pkg::OP_FREE,    13'd192,  1'b0, want);
    endtask

    // page full, back from full, largest slot and offset, null head
    task automatic test_full_and_null();
        psa_pkg::t_rsp want;
        drain();
        cfg_write(psa_pkg::CFG_SLOT_BYTES, 13'd2048);
        cfg_write(psa_pkg::CFG_FIRST_SLOT, 13'd64);
        send_req(psa_pkg::OP_RESTART, 13'd0, 1'b0, want);
        repeat (4) send_req(psa_pkg::OP_ALLOC, 13'd0, 1'b0, want);
        send_req(psa_pkg::OP_FREE, 13'd2112, 1'b0, want);
        send_req(psa_pkg::OP_ALLOC, 13'd0, 1'b0, want);
        drain();
        cfg_write(psa_pkg::CFG_SLOT_BYTES, 13'd8191);
        cfg_write(psa_pkg::CFG_FIRST_SLOT, 13'd8191);
        cfg_write(CFG_SPARE_2, 13'($urandom));
        cfg_write(CFG_SPARE_3, 13'($urandom));
        send_req(psa_pkg::OP_RESTART, 13'd0, 1'b0, want);
        send_req(psa_pkg::OP_ALLOC, 13'd0, 1'b0, want);
        send_req(psa_pkg::OP_FREE, 13'd64, 1'b0, want);
        drain();
        cfg_write(psa_pkg::CFG_FIRST_SLOT, 13'd0);
        send_req(psa_pkg::OP_RESTART, 13'd0, 1'b0, want);
        send_req(psa_pkg::OP_ALLOC, 13'd0, 1'b0, want);
    endtask

    // zero slot size never leaves the page: each bump hands out the same slot
    task automatic test_zero_slot_size();
        psa_pkg::t_rsp want;
        drain();
        cfg_write(psa_pkg::CFG_SLOT_BYTES, 13'd0);
        cfg_write(psa_pkg::CFG_FIRST_SLOT, 13'd64);
        send_req(psa_pkg::OP_RESTART, 13'd0, 1'b1, want);
        repeat (ZERO_ALLOCS) send_req(psa_pkg::OP_ALLOC, 13'd0, 1'b1, want);
        repeat (3) send_req(psa_pkg::OP_FREE, 13'd64, 1'b0, want);
        send_req(psa_pkg::OP_ALLOC, 13'd0, 1'b0, want);
        send_req(psa_pkg::OP_RESTART, 13'd0, 1'b0, want);
    endtask

    // random traffic over several page layouts: mostly frees of held slots
    // and allocates, plus stray frees, null frees, restarts and no-ops
    task automatic test_random();
        psa_pkg::t_rsp                want;
        logic [psa_pkg::OFFSET_W-1:0] slot_sz;
        logic [psa_pkg::OFFSET_W-1:0] first;
        logic [psa_pkg::OFFSET_W-1:0] off;
        int                           pick;
        int                           idx;
        bit                           calm;
        for (int phase = 0; phase < 6; phase++) begin
            case ($urandom_range(0, 5))
                0: slot_sz = 13'(8 * $urandom_range(1, 8));
                1: slot_sz = 13'(8 * $urandom_range(16, 64));
                2: slot_sz = 13'(8 * $urandom_range(128, 512));
                3: slot_sz = 13'd4096;
                4: slot_sz = 13'($urandom);
                default: slot_sz = 13'(8 * $urandom_range(1, 1023));
            endcase
            case ($urandom_range(0, 5))
                0: first = 13'd8;
                1: first = 13'd64;
                2: first = 13'($urandom);
                3: first = 13'd8191;
                default: first = 13'(8 * $urandom_range(1, 1023));
            endcase
            // the extremes get a phase of their own
            if (phase == 0) begin
                slot_sz = 13'd8;
                first   = 13'd8;
            end else if (phase == 5) begin
                slot_sz = 13'd4096;
                first   = 13'd64;
            end
            calm = ($urandom_range(0, 3) == 0);
            drain();
            cfg_write(psa_pkg::CFG_SLOT_BYTES, slot_sz);
            cfg_write(psa_pkg::CFG_FIRST_SLOT, first);
            send_req(psa_pkg::OP_RESTART, 13'd0, calm, want);
            held_slots.delete();
            repeat (PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 46 || (pick < 80 && held_slots.size() == 0)) begin
                    send_req(psa_pkg::OP_ALLOC, 13'($urandom), calm, want);
                    if (want.granted)
                        held_slots.push_back(want.slot_offset);
                end else if (pick < 80) begin
                    idx = $urandom_range(0, held_slots.size() - 1);
                    off = held_slots[idx];
                    held_slots.delete(idx);
                    send_req(psa_pkg::OP_FREE, off, calm, want);
                end else if (pick < 89) begin
                    send_req(psa_pkg::OP_FREE, 13'($urandom), calm, want);
                end else if (pick < 93) begin
                    send_req(psa_pkg::OP_FREE, 13'd0, calm, want);
                end else if (pick < 96) begin
                    send_req(psa_pkg::OP_RESTART, 13'($urandom), calm, want);
                    held_slots.delete();
                end else begin
                    send_req(psa_pkg::OP_NOP, 13'($urandom), calm, want);
                end
            end
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_req        = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        mismatches   = 0;
        stall_cycles = 0;

        // predictor reset state
        foreach (pg_link[i]) pg_link[i] = '0;
        cfg_slot_bytes = psa_pkg::SLOT_BYTES_RST;
        cfg_first_slot = psa_pkg::FIRST_SLOT_RST;
        restart_page();

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // block clears the initial head link before taking requests
        do @(posedge i_clk); while (o_busy !== 1'b0);

        test_basic_ops();
        test_full_and_null();
        test_zero_slot_size();
        test_random();

        drain();
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/psa_pkg.sv
rtl/psa_ram.sv
rtl/page_slab_slot_allocator.sv
dv/tb_page_slab_slot_allocator.sv
